>>> hdl/cbez_pkg.sv
// shared widths, word types and fixed-point helpers for the bezier point evaluator
package cbez_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_WIDTH     = T_FRAC_BITS + 1;
    // coefficient a needs 3 extra bits and b up to 12x a coordinate, so 4 bits of headroom
    localparam int COEF_WIDTH  = COORD_WIDTH + 4;
    localparam int MAG_WIDTH   = COEF_WIDTH - 1;
    localparam int PROD_WIDTH  = MAG_WIDTH + T_WIDTH;
    localparam int TSQ_WIDTH   = 2 * T_WIDTH;
    localparam int SUM_WIDTH   = COORD_WIDTH + 6;
    // register stages ahead of the output register
    localparam int PIPE_DEPTH  = 6;

    localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p0_x;
        logic signed [COORD_WIDTH-1:0] p0_y;
        logic signed [COORD_WIDTH-1:0] p1_x;
        logic signed [COORD_WIDTH-1:0] p1_y;
        logic signed [COORD_WIDTH-1:0] p2_x;
        logic signed [COORD_WIDTH-1:0] p2_y;
        logic signed [COORD_WIDTH-1:0] p3_x;
        logic signed [COORD_WIDTH-1:0] p3_y;
        logic        [T_WIDTH-1:0]     t_param;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
    } t_out_word;

    // round a 1.F by 1.F product back to 1.F, half up
    function automatic logic [T_WIDTH-1:0] t_round(input logic [TSQ_WIDTH-1:0] prod);
        logic [TSQ_WIDTH-1:0] s;
        s = prod + (TSQ_WIDTH'(1) << (T_FRAC_BITS - 1));
        return s[T_FRAC_BITS +: T_WIDTH];
    endfunction

    // magnitude of a coefficient, always below 2^MAG_WIDTH
    function automatic logic [MAG_WIDTH-1:0] coef_mag(input logic signed [COEF_WIDTH-1:0] c);
        logic [COEF_WIDTH-1:0] n;
        n = COEF_WIDTH'(0) - c;
        return c[COEF_WIDTH-1] ? n[MAG_WIDTH-1:0] : c[MAG_WIDTH-1:0];
    endfunction

    // scale a magnitude product by 2^-F, round half away from zero, reapply sign
    function automatic logic signed [COEF_WIDTH-1:0] term_round(
        input logic [PROD_WIDTH-1:0] prod,
        input logic                  neg
    );
        logic [PROD_WIDTH-1:0] s;
        logic [COEF_WIDTH-1:0] m;
        s = prod + (PROD_WIDTH'(1) << (T_FRAC_BITS - 1));
        m = s[T_FRAC_BITS +: COEF_WIDTH];
        return neg ? (COEF_WIDTH'(0) - m) : m;
    endfunction

    // clip a wide sum into the signed coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] coord_sat(
        input logic signed [SUM_WIDTH-1:0] s
    );
        logic [SUM_WIDTH-COORD_WIDTH:0] top;
        top = s[SUM_WIDTH-1:COORD_WIDTH-1];
        priority if ((&top) || (~|top)) begin
            return s[COORD_WIDTH-1:0];
        end else if (s[SUM_WIDTH-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

>>> hdl/cbez_tpow.sv
// powers of the curve parameter: t, and t^2 and t^3 rounded, all in 1.F fixed point
module cbez_tpow (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cbez_pkg::T_WIDTH-1:0]  i_t,
    output logic [cbez_pkg::T_WIDTH-1:0]  o_t1,
    output logic [cbez_pkg::T_WIDTH-1:0]  o_t2,
    output logic [cbez_pkg::T_WIDTH-1:0]  o_t3
);

    logic [cbez_pkg::T_WIDTH-1:0] r_t1;
    logic [cbez_pkg::T_WIDTH-1:0] r_t2;
    logic [cbez_pkg::T_WIDTH-1:0] r_t3;
    logic [cbez_pkg::T_WIDTH-1:0] n_t2;
    logic [cbez_pkg::T_WIDTH-1:0] n_t3;

    always_comb begin
        n_t2 = cbez_pkg::t_round(cbez_pkg::TSQ_WIDTH'(i_t) * cbez_pkg::TSQ_WIDTH'(i_t));
        n_t3 = cbez_pkg::t_round(cbez_pkg::TSQ_WIDTH'(r_t2) * cbez_pkg::TSQ_WIDTH'(r_t1));
    end

    // t1 and t2 line up with the coefficient stage, t3 one stage later
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= i_t;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
        end
    end

    assign o_t1 = r_t1;
    assign o_t2 = r_t2;
    assign o_t3 = r_t3;

endmodule

>>> hdl/cbez_lane.sv
// one coordinate lane: power-basis coefficients, scaled terms and their sum
module cbez_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [cbez_pkg::COORD_WIDTH-1:0] i_p0,
    input  logic signed [cbez_pkg::COORD_WIDTH-1:0] i_p1,
    input  logic signed [cbez_pkg::COORD_WIDTH-1:0] i_p2,
    input  logic signed [cbez_pkg::COORD_WIDTH-1:0] i_p3,
    input  logic        [cbez_pkg::T_WIDTH-1:0]     i_t1,
    input  logic        [cbez_pkg::T_WIDTH-1:0]     i_t2,
    input  logic        [cbez_pkg::T_WIDTH-1:0]     i_t3,
    output logic signed [cbez_pkg::SUM_WIDTH-1:0]   o_sum
);

    logic signed [cbez_pkg::COEF_WIDTH-1:0]  e0, e1, e2, e3;
    logic signed [cbez_pkg::COEF_WIDTH-1:0]  n_a, n_b, n_c;
    logic        [cbez_pkg::PROD_WIDTH-1:0]  n_prod_b, n_prod_c, n_prod_a;
    logic signed [cbez_pkg::SUM_WIDTH-1:0]   n_sum_bc, n_sum;

    // stage 2
    logic signed [cbez_pkg::COEF_WIDTH-1:0]  r_a, r_b, r_c;
    logic signed [cbez_pkg::COORD_WIDTH-1:0] r_p0_2;
    // stage 3
    logic        [cbez_pkg::PROD_WIDTH-1:0]  r_prod_b, r_prod_c;
    logic                                    r_neg_b, r_neg_c;
    logic        [cbez_pkg::MAG_WIDTH-1:0]   r_mag_a;
    logic                                    r_neg_a_3;
    logic signed [cbez_pkg::COORD_WIDTH-1:0] r_p0_3;
    // stage 4
    logic        [cbez_pkg::PROD_WIDTH-1:0]  r_prod_a;
    logic                                    r_neg_a_4;
    logic signed [cbez_pkg::COEF_WIDTH-1:0]  r_term_b, r_term_c;
    logic signed [cbez_pkg::COORD_WIDTH-1:0] r_p0_4;
    // stage 5
    logic signed [cbez_pkg::COEF_WIDTH-1:0]  r_term_a;
    logic signed [cbez_pkg::SUM_WIDTH-1:0]   r_sum_bc;
    logic signed [cbez_pkg::COORD_WIDTH-1:0] r_p0_5;
    // stage 6
    logic signed [cbez_pkg::SUM_WIDTH-1:0]   r_sum;

    always_comb begin
        e0 = cbez_pkg::COEF_WIDTH'(i_p0);
        e1 = cbez_pkg::COEF_WIDTH'(i_p1);
        e2 = cbez_pkg::COEF_WIDTH'(i_p2);
        e3 = cbez_pkg::COEF_WIDTH'(i_p3);
        // times 3 and times 6 as shift-adds
        n_a = e3 - ((e2 <<< 1) + e2) + ((e1 <<< 1) + e1) - e0;
        n_b = ((e2 <<< 1) + e2) - ((e1 <<< 2) + (e1 <<< 1)) + ((e0 <<< 1) + e0);
        n_c = ((e1 <<< 1) + e1) - ((e0 <<< 1) + e0);

        n_prod_c = cbez_pkg::PROD_WIDTH'(cbez_pkg::coef_mag(r_c))
                 * cbez_pkg::PROD_WIDTH'(i_t1);
        n_prod_b = cbez_pkg::PROD_WIDTH'(cbez_pkg::coef_mag(r_b))
                 * cbez_pkg::PROD_WIDTH'(i_t2);
        n_prod_a = cbez_pkg::PROD_WIDTH'(r_mag_a) * cbez_pkg::PROD_WIDTH'(i_t3);

        n_sum_bc = cbez_pkg::SUM_WIDTH'(r_term_b) + cbez_pkg::SUM_WIDTH'(r_term_c);
        n_sum    = cbez_pkg::SUM_WIDTH'(r_term_a) + r_sum_bc + cbez_pkg::SUM_WIDTH'(r_p0_5);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a       <= n_a;
            r_b       <= n_b;
            r_c       <= n_c;
            r_p0_2    <= i_p0;

            r_prod_b  <= n_prod_b;
            r_prod_c  <= n_prod_c;
            r_neg_b   <= r_b[cbez_pkg::COEF_WIDTH-1];
            r_neg_c   <= r_c[cbez_pkg::COEF_WIDTH-1];
            r_mag_a   <= cbez_pkg::coef_mag(r_a);
            r_neg_a_3 <= r_a[cbez_pkg::COEF_WIDTH-1];
            r_p0_3    <= r_p0_2;

            r_prod_a  <= n_prod_a;
            r_neg_a_4 <= r_neg_a_3;
            r_term_b  <= cbez_pkg::term_round(r_prod_b, r_neg_b);
            r_term_c  <= cbez_pkg::term_round(r_prod_c, r_neg_c);
            r_p0_4    <= r_p0_3;

            r_term_a  <= cbez_pkg::term_round(r_prod_a, r_neg_a_4);
            r_sum_bc  <= n_sum_bc;
            r_p0_5    <= r_p0_4;

            r_sum     <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> hdl/cbez_merge.sv
// merge stage: saturates both lane sums and holds the output word
module cbez_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic signed [cbez_pkg::SUM_WIDTH-1:0]  i_sum_x,
    input  logic signed [cbez_pkg::SUM_WIDTH-1:0]  i_sum_y,
    output logic                                   o_valid,
    output cbez_pkg::t_out_word                    o_word
);

    logic                r_vld;
    cbez_pkg::t_out_word r_word;
    cbez_pkg::t_out_word n_word;

    always_comb begin
        n_word.x_out = cbez_pkg::coord_sat(i_sum_x);
        n_word.y_out = cbez_pkg::coord_sat(i_sum_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

>>> hdl/cubic_bezier_point_eval.sv
// top level of the cubic bezier point evaluator
//
// each input word carries four control points (signed 26.6) and a parameter t (unsigned 1.16,
// 65536 is one, larger values clamp to one); each accepted word yields one output word with the
// curve point at t, saturated to the coordinate range. the block takes one word per clock and
// delivers one per clock while the output side does not stall: the work is a fixed pipeline of
// seven register stages (input capture, coefficients, two multiplier stages, rounding,
// summation, saturating output register). the x and y coordinates run in two identical lanes
// that share one t-power unit; the merge stage joins them into the output word. back-pressure
// on the output freezes the whole pipeline, so the input stalls exactly while a finished word
// waits in the output register and is stalled.
module cubic_bezier_point_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cbez_pkg::t_in_word  i_in_word,

    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cbez_pkg::t_out_word o_out_word
);

    // pipeline advances whenever the output register is free or being taken
    logic adv;

    // valid bit for each register stage ahead of the output register
    logic [cbez_pkg::PIPE_DEPTH-1:0] r_vld;
    logic [cbez_pkg::PIPE_DEPTH-1:0] n_vld;

    // stage 1: captured points and clamped t
    cbez_pkg::t_in_word              r_in;
    logic [cbez_pkg::T_WIDTH-1:0]    r_t;
    logic [cbez_pkg::T_WIDTH-1:0]    n_t;

    // t powers, aligned to the lane stages that use them
    logic [cbez_pkg::T_WIDTH-1:0]    t1, t2, t3;

    logic signed [cbez_pkg::SUM_WIDTH-1:0] sum_x, sum_y;

    assign adv        = ~o_out_valid | ~i_out_stall;
    assign o_in_stall = ~adv;

    always_comb begin
        // t above one reads as exactly one
        n_t   = (i_in_word.t_param > cbez_pkg::T_ONE) ? cbez_pkg::T_ONE : i_in_word.t_param;
        n_vld = {r_vld[cbez_pkg::PIPE_DEPTH-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= n_vld;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= i_in_word;
            r_t  <= n_t;
        end
    end

    cbez_tpow u_tpow (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (r_t),
        .o_t1  (t1),
        .o_t2  (t2),
        .o_t3  (t3)
    );

    cbez_lane u_lane_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_p0  (r_in.p0_x),
        .i_p1  (r_in.p1_x),
        .i_p2  (r_in.p2_x),
        .i_p3  (r_in.p3_x),
        .i_t1  (t1),
        .i_t2  (t2),
        .i_t3  (t3),
        .o_sum (sum_x)
    );

    cbez_lane u_lane_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_p0  (r_in.p0_y),
        .i_p1  (r_in.p1_y),
        .i_p2  (r_in.p2_y),
        .i_p3  (r_in.p3_y),
        .i_t1  (t1),
        .i_t2  (t2),
        .i_t3  (t3),
        .o_sum (sum_y)
    );

    // saturation and output word register
    cbez_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_vld[cbez_pkg::PIPE_DEPTH-1]),
        .i_sum_x (sum_x),
        .i_sum_y (sum_y),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

>>> hdl/cbez_checker.sv
// port-level checks for the bezier point evaluator, bound to the top level
module cbez_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cbez_pkg::t_out_word o_out_word
);

    // input stalls only while a finished word is held by the output side
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output word");

    // input never stalls while the output side can take a word
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && i_out_stall) |-> !o_in_stall)
        else $error("input stalled although the output can move");

    // a stalled output word stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed or dropped");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind cubic_bezier_point_eval cbez_checker u_cbez_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

>>> tb/testbench.sv
// self-checking testbench for the cubic bezier point evaluator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // saturation bounds and fixed-point constants at the block's widths
    localparam longint COORD_MAX = (longint'(1) << (cbez_pkg::COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (cbez_pkg::COORD_WIDTH - 1));
    localparam logic signed [cbez_pkg::COORD_WIDTH-1:0] COORD_HI =
        COORD_MAX[cbez_pkg::COORD_WIDTH-1:0];
    localparam logic signed [cbez_pkg::COORD_WIDTH-1:0] COORD_LO =
        COORD_MIN[cbez_pkg::COORD_WIDTH-1:0];
    localparam longint unsigned T_UNIT   = longint'(1) << cbez_pkg::T_FRAC_BITS;
    localparam longint unsigned HALF_LSB = longint'(1) << (cbez_pkg::T_FRAC_BITS - 1);
    localparam longint unsigned T_FIELD_MAX = (longint'(1) << cbez_pkg::T_WIDTH) - 1;

    // predicts curve points for accepted words and checks the delivered ones in order
    class curve_point_board;
        cbez_pkg::t_out_word pending_points[$];
        int                  errors = 0;

        // one line per problem, and count it
        task flag_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // coef * tp / 2^F, rounded to nearest with ties away from zero
        function longint scaled_term(longint coef, longint unsigned tp);
            longint unsigned mag;
            longint unsigned r;
            mag = (coef < 0) ? -coef : coef;
            r = (mag * tp + HALF_LSB) >> cbez_pkg::T_FRAC_BITS;
            return (coef < 0) ? -longint'(r) : longint'(r);
        endfunction

        // one coordinate of the curve point from the power-basis coefficients
        function logic signed [cbez_pkg::COORD_WIDTH-1:0] coord_at(
            input logic signed [cbez_pkg::COORD_WIDTH-1:0] p0, p1, p2, p3,
            input longint unsigned t1, t2, t3
        );
            longint a0, a1, a2, a3;
            longint ka, kb, kc, total;
            a0 = p0;
            a1 = p1;
            a2 = p2;
            a3 = p3;
            ka = a3 - 3 * a2 + 3 * a1 - a0;
            kb = 3 * a2 - 6 * a1 + 3 * a0;
            kc = 3 * a1 - 3 * a0;
            total = scaled_term(ka, t3) + scaled_term(kb, t2) + scaled_term(kc, t1) + a0;
            if (total > COORD_MAX) total = COORD_MAX;
            if (total < COORD_MIN) total = COORD_MIN;
            return total[cbez_pkg::COORD_WIDTH-1:0];
        endfunction

        function void note_input(cbez_pkg::t_in_word w);
            longint unsigned t1, t2, t3;
            cbez_pkg::t_out_word pt;
            t1 = w.t_param;
            if (t1 > T_UNIT) t1 = T_UNIT;
            t2 = (t1 * t1 + HALF_LSB) >> cbez_pkg::T_FRAC_BITS;
            t3 = (t2 * t1 + HALF_LSB) >> cbez_pkg::T_FRAC_BITS;
            pt.x_out = coord_at(w.p0_x, w.p1_x, w.p2_x, w.p3_x, t1, t2, t3);
            pt.y_out = coord_at(w.p0_y, w.p1_y, w.p2_y, w.p3_y, t1, t2, t3);
            pending_points.push_back(pt);
        endfunction

        task check_result(cbez_pkg::t_out_word got);
            cbez_pkg::t_out_word pt;
            if (pending_points.size() == 0) begin
                flag_mismatch($sformatf("unexpected word x=%0d y=%0d", got.x_out, got.y_out));
            end else begin
                pt = pending_points.pop_front();
                if (got.x_out !== pt.x_out)
                    flag_mismatch($sformatf("x got %0d expected %0d", got.x_out, pt.x_out));
                if (got.y_out !== pt.y_out)
                    flag_mismatch($sformatf("y got %0d expected %0d", got.y_out, pt.y_out));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    cbez_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    cbez_pkg::t_out_word o_out_word;

    // idle and stall odds in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    curve_point_board sb = new;

    cubic_bezier_point_eval dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver back-pressure, drawn fresh each cycle at the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // both handshakes sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_input(i_in_word);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    // mix of rail values, near-rail values, small values and raw random bits
    function automatic logic signed [cbez_pkg::COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_HI;
            1: return COORD_LO;
            2: return COORD_HI - $urandom_range(0, 255);
            3: return COORD_LO + $urandom_range(0, 255);
            4: return $urandom_range(0, 4000) - 2000;
            default: return $urandom();
        endcase
    endfunction

    // mostly in [0, 1], with the ends and the clamped range hit often
    function automatic logic [cbez_pkg::T_WIDTH-1:0] pick_t();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return cbez_pkg::T_WIDTH'(T_UNIT);
            2: return cbez_pkg::T_WIDTH'($urandom_range(32'(T_UNIT + 1), 32'(T_FIELD_MAX)));
            3: return cbez_pkg::T_WIDTH'($urandom_range(0, 63));
            default: return cbez_pkg::T_WIDTH'($urandom_range(0, 32'(T_UNIT)));
        endcase
    endfunction

    // one word through the input handshake; entered and left at a falling edge.
    // valid stays high on exit so back-to-back words need no second assignment
    task automatic send_word(cbez_pkg::t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // random segments, each sampled at a few t values as a flattener would
    task automatic run_phase(int idle_pct, int stall_pct, int n_words);
        cbez_pkg::t_in_word w;
        int left;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        left = n_words;
        while (left > 0) begin
            w.p0_x = pick_coord();
            w.p0_y = pick_coord();
            w.p1_x = pick_coord();
            w.p1_y = pick_coord();
            w.p2_x = pick_coord();
            w.p2_y = pick_coord();
            w.p3_x = pick_coord();
            w.p3_y = pick_coord();
            repeat ($urandom_range(1, 6)) begin
                w.t_param = pick_t();
                send_word(w);
                left--;
            end
        end
    endtask

    // directed corners: t at zero, one, just inside and past one, clamp at all ones,
    // each paired with rail-to-rail control points to push the sum into saturation
    logic [cbez_pkg::T_WIDTH-1:0] corner_t [10] = '{
        '0, cbez_pkg::T_WIDTH'(1), cbez_pkg::T_WIDTH'(255), cbez_pkg::T_WIDTH'(21845),
        cbez_pkg::T_WIDTH'(32768), cbez_pkg::T_WIDTH'(43691), cbez_pkg::T_WIDTH'(65535),
        cbez_pkg::T_WIDTH'(65536), cbez_pkg::T_WIDTH'(65537), '1
    };

    initial begin
        cbez_pkg::t_in_word w;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all-zero word, then a plain segment at both ends of t
        w = '0;
        send_word(w);
        w.p0_x = 32'sd100;  w.p1_x = 32'sd200;  w.p2_x = 32'sd300;  w.p3_x = 32'sd400;
        w.p0_y = -32'sd5;   w.p1_y = 32'sd640;  w.p2_y = -32'sd640; w.p3_y = 32'sd7;
        w.t_param = '0;
        send_word(w);
        w.t_param = cbez_pkg::T_WIDTH'(T_UNIT);
        send_word(w);

        // alternating rails, then a hump that overshoots once t powers are rounded
        foreach (corner_t[i]) begin
            w.p0_x = COORD_HI;  w.p1_x = COORD_LO;  w.p2_x = COORD_HI;  w.p3_x = COORD_LO;
            w.p0_y = COORD_LO;  w.p1_y = COORD_HI;  w.p2_y = COORD_LO;  w.p3_y = COORD_HI;
            w.t_param = corner_t[i];
            send_word(w);
            w.p0_x = COORD_HI;  w.p1_x = COORD_HI;  w.p2_x = COORD_LO;  w.p3_x = COORD_LO;
            w.p0_y = COORD_LO;  w.p1_y = COORD_HI;  w.p2_y = COORD_HI;  w.p3_y = COORD_LO;
            send_word(w);
        end

        // random part across the idling mixes
        run_phase(0, 0, 140);
        run_phase(80, 0, 135);
        run_phase(0, 80, 135);
        run_phase(19, 19, 140);
        i_in_valid <= 1'b0;

        // drain, then keep clocking on to catch stray words
        while (sb.pending_points.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cbez_pkg.sv
hdl/cbez_tpow.sv
hdl/cbez_lane.sv
hdl/cbez_merge.sv
hdl/cubic_bezier_point_eval.sv
hdl/cbez_checker.sv
tb/testbench.sv
